// ----- hdl/prqs_pkg.sv -----
// ---------------------------------------------------------------------------
// prqs_pkg
// shared constants, codes and control structs of the ready-queue scheduler
// ---------------------------------------------------------------------------
package prqs_pkg;

  localparam int DEF_MAX_THREADS     = 64;
  localparam int DEF_PRIORITY_LEVELS = 32;

  localparam int ID_W   = 6;
  localparam int PRIO_W = 5;
  localparam int KIND_W = 3;
  localparam int NEST_W = 16;
  localparam logic [NEST_W-1:0] NEST_MAX = 16'hFFFF;

  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SCHED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ENTER  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXIT   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_START  = 3'd5;

  // level address select for the head and tail memories
  localparam logic [1:0] LV_PR   = 2'd0;
  localparam logic [1:0] LV_TP   = 2'd1;
  localparam logic [1:0] LV_BEST = 2'd2;

  typedef struct packed {
    logic       load;
    logic       cur_from_run;
    logic       nest_inc;
    logic       nest_dec;
    logic       pend_set;
    logic       pend_clr;
    logic       set_deferred;
    logic       set_fault;
    logic       cap_h;
    logic       cap_cand;
    logic       enq_wr;
    logic       deq_wr;
    logic       deq_cand;
    logic [1:0] lv_sel;
    logic       run_keep;
    logic       run_cand;
    logic       cap_out;
  } prqs_cmd_t;

  typedef struct packed {
    logic kind_insert;
    logic kind_remove;
    logic kind_sched;
    logic kind_enter;
    logic kind_exit;
    logic kind_start;
    logic cur_ok;
    logic queued_cur;
    logic is_running;
    logic nest_zero;
    logic nest_le1;
    logic pending;
    logic any_ready;
    logic keep;
    logic requeue;
  } prqs_stat_t;

endpackage

// ----- hdl/priority_ready_queue_scheduler.sv -----
// ---------------------------------------------------------------------------
// priority_ready_queue_scheduler
// fixed-priority ready-queue scheduler with per-level linked lists
// ---------------------------------------------------------------------------
// One item is taken at a time and gives one result. Enter critical, deferred
// schedules, plain exits and rejected items do not touch the link memories.
// A schedule, or an exit that runs a pending schedule, reads the queue head,
// optionally requeues the current thread and then unlinks; each read of the
// synchronous link memories is registered before its write-back. A finished
// result waits in the output register while the next item is taken; a result
// still waiting when the next one is done holds that item until it leaves.
module priority_ready_queue_scheduler
  import prqs_pkg::*;
#(
  parameter int MAX_THREADS     = DEF_MAX_THREADS,
  parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // thread_id, priority_req, yield_flag, current_runnable
  input  logic [2:0]  in_tuser,  // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata  // switched, from_id, to_id, to_priority,
                                 // deferred, nest_level, ready_empty, fault
);

  prqs_cmd_t  cmd;
  prqs_stat_t stat;

  prqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_tvalid & in_tready),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  prqs_datapath #(
    .MAX_THREADS     (MAX_THREADS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_kind             (in_tuser),
    .in_thread_id        (in_tdata[5:0]),
    .in_priority_req     (in_tdata[10:6]),
    .in_yield_flag       (in_tdata[11]),
    .in_current_runnable (in_tdata[12]),
    .out_data            (out_tdata)
  );

endmodule

// ----- hdl/prqs_datapath.sv -----
// ---------------------------------------------------------------------------
// prqs_datapath
// link memories, ready bitmap, running thread and result registers
// ---------------------------------------------------------------------------
module prqs_datapath
  import prqs_pkg::*;
#(
  parameter int MAX_THREADS     = DEF_MAX_THREADS,
  parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  prqs_cmd_t         cmd,
  output prqs_stat_t        stat,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [ID_W-1:0]   in_thread_id,
  input  logic [PRIO_W-1:0] in_priority_req,
  input  logic              in_yield_flag,
  input  logic              in_current_runnable,
  output logic [39:0]       out_data
);

  localparam int TW  = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int LW  = $clog2(PRIORITY_LEVELS);
  localparam int IDW = (TW > ID_W) ? TW : ID_W;

  logic [TW-1:0] next_mem [MAX_THREADS];
  logic [TW-1:0] prev_mem [MAX_THREADS];
  logic [LW-1:0] prio_mem [MAX_THREADS];
  logic [TW-1:0] head_mem [PRIORITY_LEVELS];
  logic [TW-1:0] tail_mem [PRIORITY_LEVELS];

  logic [TW-1:0] nx_q, pv_q, hd_q, tl_q;
  logic [LW-1:0] tp_q;

  logic [MAX_THREADS-1:0]     mark_r;
  logic [PRIORITY_LEVELS-1:0] bitmap_r;
  logic [IDW-1:0]             run_thr_r;
  logic [LW-1:0]              run_prio_r;
  logic                       run_valid_r;
  logic [NEST_W-1:0]          nest_r;
  logic                       pend_r;

  logic [KIND_W-1:0] kind_r;
  logic [IDW-1:0]    cur_r;
  logic [LW-1:0]     pr_r;
  logic              yld_r;
  logic              run_r;
  logic [LW-1:0]     h_r;
  logic [TW-1:0]     cand_r;
  logic [LW-1:0]     dlv_r;
  logic              switched_r, deferred_r, fault_r;
  logic [IDW-1:0]    from_r;
  logic [39:0]       out_r;

  logic [LW-1:0]  best;
  logic [LW-1:0]  rd_lv;
  logic [LW-1:0]  pr_clamp;
  logic [TW-1:0]  cur_idx;
  logic [TW-1:0]  deq_t;
  logic           cur_ok;
  logic           prio_keep;
  logic           run_eff;
  logic [31:0]    run_thr_ext, run_prio_ext, from_ext;

  logic          hd_we, tl_we, nx_we, pv_we;
  logic [LW-1:0] ht_wa;
  logic [TW-1:0] hd_wd, tl_wd, nx_wa, nx_wd, pv_wa, pv_wd;

  always_comb begin
    best = '0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (bitmap_r[i]) begin
        best = LW'(i);
      end
    end
  end

  assign pr_clamp = (32'(in_priority_req) >= PRIORITY_LEVELS) ?
                    LW'(PRIORITY_LEVELS - 1) : LW'(in_priority_req);
  assign cur_idx  = cur_r[TW-1:0];
  assign cur_ok   = 32'(cur_r) < MAX_THREADS;
  assign deq_t    = cmd.deq_cand ? cand_r : cur_idx;
  assign run_eff  = run_r && cur_ok;
  assign prio_keep = (pr_r < h_r) || (pr_r == h_r && !yld_r);

  always_comb begin
    case (cmd.lv_sel)
      LV_PR:   rd_lv = pr_r;
      LV_TP:   rd_lv = tp_q;
      LV_BEST: rd_lv = best;
      default: rd_lv = pr_r;
    endcase
  end

  // write port selection for enqueue and unlink
  always_comb begin
    hd_we = 1'b0; tl_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
    ht_wa = dlv_r;
    hd_wd = nx_q; tl_wd = pv_q;
    nx_wa = pv_q; nx_wd = nx_q;
    pv_wa = nx_q; pv_wd = pv_q;
    if (cmd.enq_wr) begin
      ht_wa = pr_r;
      hd_wd = cur_idx;
      tl_wd = cur_idx;
      if (!bitmap_r[pr_r]) begin
        hd_we = 1'b1;
        tl_we = 1'b1;
      end else if (yld_r) begin
        pv_we = 1'b1; pv_wa = cur_idx; pv_wd = tl_q;
        nx_we = 1'b1; nx_wa = tl_q;    nx_wd = cur_idx;
        tl_we = 1'b1;
      end else begin
        nx_we = 1'b1; nx_wa = cur_idx; nx_wd = hd_q;
        pv_we = 1'b1; pv_wa = hd_q;    pv_wd = cur_idx;
        hd_we = 1'b1;
      end
    end else if (cmd.deq_wr) begin
      if (hd_q == deq_t && tl_q == deq_t) begin
        hd_we = 1'b0;
      end else if (hd_q == deq_t) begin
        hd_we = 1'b1;
      end else if (tl_q == deq_t) begin
        tl_we = 1'b1;
      end else begin
        nx_we = 1'b1;
        pv_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hd_we) head_mem[ht_wa] <= hd_wd;
    if (tl_we) tail_mem[ht_wa] <= tl_wd;
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (cmd.enq_wr) prio_mem[cur_idx] <= pr_r;
    hd_q <= head_mem[rd_lv];
    tl_q <= tail_mem[rd_lv];
    nx_q <= next_mem[deq_t];
    pv_q <= prev_mem[deq_t];
    tp_q <= prio_mem[deq_t];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r      <= '0;
      bitmap_r    <= '0;
      run_thr_r   <= '0;
      run_prio_r  <= '0;
      run_valid_r <= 1'b0;
      nest_r      <= '0;
      pend_r      <= 1'b0;
    end else begin
      if (cmd.enq_wr) begin
        mark_r[cur_idx] <= 1'b1;
        bitmap_r[pr_r]  <= 1'b1;
      end
      if (cmd.deq_wr) begin
        mark_r[deq_t] <= 1'b0;
        if (hd_q == deq_t && tl_q == deq_t) bitmap_r[dlv_r] <= 1'b0;
      end
      if (cmd.run_keep) begin
        run_thr_r   <= cur_r;
        run_prio_r  <= pr_r;
        run_valid_r <= 1'b1;
      end
      if (cmd.run_cand) begin
        run_thr_r   <= IDW'(cand_r);
        run_prio_r  <= h_r;
        run_valid_r <= 1'b1;
      end
      if (cmd.nest_inc && nest_r != NEST_MAX) nest_r <= nest_r + 1'b1;
      if (cmd.nest_dec && nest_r != '0) nest_r <= nest_r - 1'b1;
      if (cmd.pend_set) pend_r <= 1'b1;
      if (cmd.pend_clr) pend_r <= 1'b0;
    end
  end

  // item and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r     <= in_kind;
      cur_r      <= IDW'(in_thread_id);
      pr_r       <= pr_clamp;
      yld_r      <= in_yield_flag;
      run_r      <= in_current_runnable;
      switched_r <= 1'b0;
      deferred_r <= 1'b0;
      fault_r    <= 1'b0;
      from_r     <= '0;
    end
    if (cmd.cur_from_run) begin
      cur_r <= run_thr_r;
      run_r <= run_r & run_valid_r;
    end
    if (cmd.cap_h) h_r <= best;
    if (cmd.cap_cand) cand_r <= hd_q;
    if (cmd.lv_sel == LV_TP) dlv_r <= tp_q;
    if (cmd.set_deferred) deferred_r <= 1'b1;
    if (cmd.set_fault) fault_r <= 1'b1;
    if (cmd.run_cand) begin
      switched_r <= 1'b1;
      from_r     <= cur_r;
    end
    if (cmd.cap_out) begin
      out_r <= {3'b000, fault_r, ~|bitmap_r, nest_r, deferred_r,
                run_valid_r ? run_prio_ext[PRIO_W-1:0] : {PRIO_W{1'b0}},
                run_valid_r ? run_thr_ext[ID_W-1:0] : {ID_W{1'b0}},
                from_ext[ID_W-1:0], switched_r};
    end
  end

  assign run_thr_ext  = 32'(run_thr_r);
  assign run_prio_ext = 32'(run_prio_r);
  assign from_ext     = 32'(from_r);
  assign out_data     = out_r;

  assign stat.kind_insert = kind_r == KIND_INSERT;
  assign stat.kind_remove = kind_r == KIND_REMOVE;
  assign stat.kind_sched  = kind_r == KIND_SCHED;
  assign stat.kind_enter  = kind_r == KIND_ENTER;
  assign stat.kind_exit   = kind_r == KIND_EXIT;
  assign stat.kind_start  = kind_r == KIND_START;
  assign stat.cur_ok      = cur_ok;
  assign stat.queued_cur  = cur_ok && mark_r[cur_idx];
  assign stat.is_running  = run_valid_r && run_thr_r == cur_r;
  assign stat.nest_zero   = nest_r == '0;
  assign stat.nest_le1    = nest_r <= NEST_W'(1);
  assign stat.pending     = pend_r;
  assign stat.any_ready   = |bitmap_r;
  assign stat.keep        = (run_eff && prio_keep) || (IDW'(cand_r) == cur_r);
  assign stat.requeue     = run_eff && !prio_keep;

endmodule

// ----- hdl/prqs_ctrl.sv -----
// ---------------------------------------------------------------------------
// prqs_ctrl
// sequencer for insert, unlink, schedule, start and critical-section items
// ---------------------------------------------------------------------------
module prqs_ctrl
  import prqs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  prqs_stat_t stat,
  output prqs_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_SCH  = 4'd2;
  localparam logic [3:0] S_HD1  = 4'd3;
  localparam logic [3:0] S_HD2  = 4'd4;
  localparam logic [3:0] S_DCD  = 4'd5;
  localparam logic [3:0] S_ENQ1 = 4'd6;
  localparam logic [3:0] S_ENQ2 = 4'd7;
  localparam logic [3:0] S_DEQ1 = 4'd8;
  localparam logic [3:0] S_DEQ2 = 4'd9;
  localparam logic [3:0] S_DEQ3 = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       chain_r, chain_nxt;
  logic       dcand_r, dcand_nxt;
  logic       start_r, start_nxt;
  logic       ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    chain_nxt = chain_r;
    dcand_nxt = dcand_r;
    start_nxt = start_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    cmd.deq_cand = dcand_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          chain_nxt = 1'b0;
          start_nxt = 1'b0;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_FIN;
        if (stat.kind_insert) begin
          if (!stat.cur_ok || stat.queued_cur) cmd.set_fault = 1'b1;
          else if (!stat.is_running) state_nxt = S_ENQ1;
        end else if (stat.kind_remove) begin
          if (!stat.cur_ok || !stat.queued_cur) begin
            cmd.set_fault = 1'b1;
          end else begin
            dcand_nxt = 1'b0;
            state_nxt = S_DEQ1;
          end
        end else if (stat.kind_sched) begin
          if (!stat.nest_zero) begin
            cmd.pend_set     = 1'b1;
            cmd.set_deferred = 1'b1;
          end else begin
            state_nxt = S_SCH;
          end
        end else if (stat.kind_enter) begin
          cmd.nest_inc = 1'b1;
        end else if (stat.kind_exit) begin
          cmd.nest_dec = 1'b1;
          if (stat.nest_le1 && stat.pending) begin
            cmd.pend_clr     = 1'b1;
            cmd.cur_from_run = 1'b1;
            state_nxt        = S_SCH;
          end
        end else if (stat.kind_start) begin
          if (stat.any_ready) begin
            cmd.pend_clr     = 1'b1;
            cmd.cur_from_run = 1'b1;
            start_nxt        = 1'b1;
            state_nxt        = S_HD1;
          end
        end
      end
      S_SCH: begin
        if (!stat.any_ready) begin
          cmd.run_keep = 1'b1;
          state_nxt    = S_FIN;
        end else begin
          state_nxt = S_HD1;
        end
      end
      S_HD1: begin
        cmd.lv_sel = LV_BEST;
        cmd.cap_h  = 1'b1;
        state_nxt  = S_HD2;
      end
      S_HD2: begin
        cmd.cap_cand = 1'b1;
        state_nxt    = S_DCD;
      end
      S_DCD: begin
        if (start_r) begin
          cmd.run_cand = 1'b1;
          dcand_nxt    = 1'b1;
          state_nxt    = S_DEQ1;
        end else if (stat.keep) begin
          cmd.run_keep = 1'b1;
          dcand_nxt    = 1'b0;
          state_nxt    = stat.queued_cur ? S_DEQ1 : S_FIN;
        end else begin
          cmd.run_cand = 1'b1;
          dcand_nxt    = 1'b1;
          if (stat.requeue && !stat.queued_cur) begin
            chain_nxt = 1'b1;
            state_nxt = S_ENQ1;
          end else begin
            state_nxt = S_DEQ1;
          end
        end
      end
      S_ENQ1: begin
        cmd.lv_sel = LV_PR;
        state_nxt  = S_ENQ2;
      end
      S_ENQ2: begin
        cmd.enq_wr = 1'b1;
        state_nxt  = chain_r ? S_DEQ1 : S_FIN;
      end
      S_DEQ1: begin
        state_nxt = S_DEQ2;
      end
      S_DEQ2: begin
        cmd.lv_sel = LV_TP;
        state_nxt  = S_DEQ3;
      end
      S_DEQ3: begin
        cmd.deq_wr = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!ov_r || out_ready) begin
          cmd.cap_out = 1'b1;
          ov_nxt      = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chain_r <= 1'b0;
      dcand_r <= 1'b0;
      start_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chain_r <= chain_nxt;
      dcand_r <= dcand_nxt;
      start_r <= start_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = ov_r;

endmodule

// ----- hdl/prqs_checker.sv -----
// ---------------------------------------------------------------------------
// prqs_checker
// port-level checks of the ready-queue scheduler
// ---------------------------------------------------------------------------
module prqs_sva (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[0] || out_tdata[6:1] == 6'd0)
    else $error("from thread without switch");

  a_defer_noswitch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[18]))
    else $error("deferred schedule switched");

endmodule

bind priority_ready_queue_scheduler prqs_sva u_prqs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- dv/prqs_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// prqs_checker
// watches both streams of the ready-queue scheduler, predicts every result
// from its own copy of the queues and compares it, reporting each field on a mismatch
// ---------------------------------------------------------------------------
module prqs_checker
  import prqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          pending_results
);

  logic [5:0]  nxt [64];
  logic [5:0]  prv [64];
  logic [5:0]  qhead [32];
  logic [5:0]  qtail [32];
  logic [4:0]  tprio [64];
  logic        queued [64];
  logic [31:0] bitmap;
  logic [5:0]  run_id;
  logic [4:0]  run_pr;
  logic        run_vld;
  logic [15:0] nest;
  logic        pend;

  logic [39:0] sched_results [$];

  assign pending_results = sched_results.size();

  function automatic logic [4:0] best_lv();
    for (int i = 0; i < 32; i++) if (bitmap[i]) return i[4:0];
    return 5'd0;
  endfunction

  function automatic void link_in(logic [5:0] t, logic [4:0] lv, logic at_tail);
    tprio[t] = lv;
    queued[t] = 1'b1;
    if (!bitmap[lv]) begin
      qhead[lv] = t;
      qtail[lv] = t;
      bitmap[lv] = 1'b1;
    end else if (at_tail) begin
      prv[t] = qtail[lv];
      nxt[qtail[lv]] = t;
      qtail[lv] = t;
    end else begin
      nxt[t] = qhead[lv];
      prv[qhead[lv]] = t;
      qhead[lv] = t;
    end
  endfunction

  function automatic void unlink(logic [5:0] t);
    logic [4:0] lv;
    logic hd, tl;
    lv = tprio[t];
    hd = qhead[lv] == t;
    tl = qtail[lv] == t;
    queued[t] = 1'b0;
    if (hd && tl) bitmap[lv] = 1'b0;
    else if (hd) qhead[lv] = nxt[t];
    else if (tl) qtail[lv] = prv[t];
    else begin
      nxt[prv[t]] = nxt[t];
      prv[nxt[t]] = prv[t];
    end
  endfunction

  function automatic logic decide(logic [5:0] cur, logic [4:0] pr, logic yl,
                                  logic rn, output logic [5:0] from);
    logic [4:0] h;
    logic [5:0] cand;
    logic keep, requeue;
    from = 6'd0;
    keep = 1'b0;
    requeue = 1'b0;
    if (bitmap == 32'd0) begin
      run_id = cur; run_pr = pr; run_vld = 1'b1;
      return 1'b0;
    end
    h = best_lv();
    cand = qhead[h];
    if (rn) begin
      if (pr < h || (pr == h && !yl)) keep = 1'b1;
      else requeue = 1'b1;
    end
    if (cand == cur) keep = 1'b1;
    if (keep) begin
      if (queued[cur]) unlink(cur);
      run_id = cur; run_pr = pr; run_vld = 1'b1;
      return 1'b0;
    end
    if (requeue && !queued[cur]) link_in(cur, pr, yl);
    unlink(cand);
    from = cur;
    run_id = cand; run_pr = h; run_vld = 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [39:0] predict(logic [2:0] kind, logic [15:0] d);
    logic [5:0] tid, from;
    logic [4:0] pr, h;
    logic yl, rn, sw, dfr, flt;
    tid = d[5:0]; pr = d[10:6]; yl = d[11]; rn = d[12];
    sw = 1'b0; dfr = 1'b0; flt = 1'b0; from = 6'd0;
    case (kind)
      KIND_INSERT: begin
        if (queued[tid]) flt = 1'b1;
        else if (!(run_vld && run_id == tid)) link_in(tid, pr, yl);
      end
      KIND_REMOVE: begin
        if (!queued[tid]) flt = 1'b1;
        else unlink(tid);
      end
      KIND_SCHED: begin
        if (nest != 0) begin
          pend = 1'b1; dfr = 1'b1;
        end else sw = decide(tid, pr, yl, rn, from);
      end
      KIND_ENTER: if (nest != NEST_MAX) nest++;
      KIND_EXIT: begin
        if (nest != 0) nest--;
        if (nest == 0 && pend) begin
          pend = 1'b0;
          sw = decide(run_id, pr, yl, rn && run_vld, from);
        end
      end
      KIND_START: begin
        if (bitmap != 0) begin
          h = best_lv();
          from = run_id;
          pend = 1'b0;
          tid = qhead[h];
          unlink(tid);
          run_id = tid; run_pr = h; run_vld = 1'b1; sw = 1'b1;
        end
      end
      default: ;
    endcase
    return {3'b000, flt, bitmap == 0, nest, dfr, run_vld ? run_pr : 5'd0,
            run_vld ? run_id : 6'd0, sw ? from : 6'd0, sw};
  endfunction

  always @(posedge clk) begin
    logic [39:0] exp_r;
    if (!rst_n) begin
      for (int i = 0; i < 64; i++) queued[i] = 1'b0;
      bitmap = '0; run_id = '0; run_pr = '0; run_vld = 1'b0;
      nest = '0; pend = 1'b0;
      fail_count <= 0;
      sched_results.delete();
    end else begin
      if (in_tvalid && in_tready) sched_results.push_back(predict(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (sched_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = sched_results.pop_front();
          if (exp_r !== out_tdata) begin
            $display("%0t: mismatch sw %b/%b from %0d/%0d to %0d/%0d prio %0d/%0d",
                     $time, exp_r[0], out_tdata[0], exp_r[6:1], out_tdata[6:1],
                     exp_r[12:7], out_tdata[12:7], exp_r[17:13], out_tdata[17:13]);
            $display("%0t:   deferred %b/%b nest %0d/%0d empty %b/%b fault %b/%b",
                     $time, exp_r[18], out_tdata[18], exp_r[34:19], out_tdata[34:19],
                     exp_r[35], out_tdata[35], exp_r[36], out_tdata[36]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- dv/tb_priority_ready_queue_scheduler.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_priority_ready_queue_scheduler
// drives directed and random scheduler commands with random idling on both
// streams; the checker beside the block predicts and compares every result
// ---------------------------------------------------------------------------
module tb_priority_ready_queue_scheduler;
  import prqs_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  int          fail_count;
  int          pending_results;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          cycle_count = 0;

  priority_ready_queue_scheduler uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  prqs_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

  task automatic send_cmd(logic [2:0] kind, logic [5:0] tid, logic [4:0] pr,
                          logic yl, logic rn);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {3'b000, rn, yl, pr, tid};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly a small pool of threads so queues fill and recycle
  task automatic send_random();
    int r;
    logic [2:0] k;
    logic [5:0] t;
    r = $urandom_range(99);
    if (r < 35) k = KIND_INSERT;
    else if (r < 50) k = KIND_REMOVE;
    else if (r < 75) k = KIND_SCHED;
    else if (r < 84) k = KIND_ENTER;
    else if (r < 93) k = KIND_EXIT;
    else if (r < 98) k = KIND_START;
    else k = 3'($urandom_range(7, 6));
    t = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(11));
    send_cmd(k, t, ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(3)),
             1'($urandom), 1'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_INSERT;
    send_idle_pct = 24;
    recv_idle_pct = 79;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cmd(KIND_SCHED, 6'd0, 5'd0, 1'b0, 1'b0);
    send_cmd(KIND_START, 6'd0, 5'd0, 1'b0, 1'b0);
    send_cmd(KIND_REMOVE, 6'd5, 5'd0, 1'b0, 1'b0);
    send_cmd(KIND_INSERT, 6'd63, 5'd31, 1'b1, 1'b0);
    send_cmd(KIND_INSERT, 6'd63, 5'd31, 1'b0, 1'b0);
    send_cmd(KIND_INSERT, 6'd1, 5'd0, 1'b0, 1'b0);
    send_cmd(KIND_INSERT, 6'd2, 5'd0, 1'b1, 1'b0);
    send_cmd(KIND_INSERT, 6'd3, 5'd0, 1'b0, 1'b0);
    send_cmd(KIND_START, 6'd0, 5'd0, 1'b0, 1'b0);
    send_cmd(KIND_INSERT, 6'd3, 5'd4, 1'b0, 1'b0);
    send_cmd(KIND_SCHED, 6'd3, 5'd0, 1'b1, 1'b1);
    send_cmd(KIND_SCHED, 6'd1, 5'd0, 1'b0, 1'b1);
    send_cmd(KIND_ENTER, 6'd0, 5'd0, 1'b0, 1'b0);
    send_cmd(KIND_ENTER, 6'd0, 5'd0, 1'b0, 1'b0);
    send_cmd(KIND_SCHED, 6'd1, 5'd0, 1'b1, 1'b1);
    send_cmd(KIND_EXIT, 6'd0, 5'd3, 1'b1, 1'b1);
    send_cmd(KIND_EXIT, 6'd0, 5'd3, 1'b1, 1'b1);
    send_cmd(KIND_EXIT, 6'd0, 5'd3, 1'b0, 1'b0);
    send_cmd(KIND_REMOVE, 6'd63, 5'd0, 1'b0, 1'b0);
    send_cmd(3'd6, 6'd63, 5'd31, 1'b1, 1'b1);
    send_cmd(3'd7, 6'd0, 5'd0, 1'b0, 1'b0);
    send_cmd(KIND_SCHED, 6'd63, 5'd31, 1'b1, 1'b0);

    for (int i = 0; i < 1050; i++) begin
      if (i == 350) begin
        send_idle_pct = 79;
        recv_idle_pct = 24;
      end
      if (i == 700) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == 500) while (pending_results != 0) @(posedge clk);
      // deep nesting once
      if (i == 800) begin
        for (int j = 0; j < 20; j++) send_cmd(KIND_ENTER, 6'd0, 5'd0, 1'b0, 1'b0);
      end
      send_random();
    end
    // count clamp at zero
    send_cmd(KIND_SCHED, 6'd2, 5'd1, 1'b0, 1'b1);
    for (int j = 0; j < 30; j++) send_cmd(KIND_EXIT, 6'd0, 5'd1, 1'b1, 1'b1);

    while (pending_results != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/prqs_pkg.sv
hdl/prqs_datapath.sv
hdl/prqs_ctrl.sv
hdl/priority_ready_queue_scheduler.sv
hdl/prqs_checker.sv
dv/prqs_checker.sv
dv/tb_priority_ready_queue_scheduler.sv
